[sv/chct_pkg.sv]
package chct_pkg;

    localparam logic [31:0] HASH_MULT = 32'h27d4eb2d;
    localparam int HASH_SHIFT_A = 16;
    localparam int HASH_SHIFT_B = 13;
    localparam int HASH_W = 32;
    localparam int CFG_W = 11;

    localparam logic [10:0] BUCKET_COUNT_RST = 11'd1024;
    localparam logic [3:0] EMPTY_CODE_RST = 4'd2;

    typedef enum logic {
        CFG_BUCKET_COUNT = 1'b0,
        CFG_EMPTY_CODE   = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        RES_HIT  = 3'd0,
        RES_UPD  = 3'd1,
        RES_INS  = 3'd2,
        RES_REM  = 3'd3,
        RES_MISS = 3'd4
    } t_res;

    typedef struct packed {
        logic               func;
        logic signed [15:0] x_coord;
        logic signed [15:0] y_coord;
        logic [3:0]         new_state;
    } t_item;

    typedef struct packed {
        logic       ok;
        logic [2:0] status;
        logic [3:0] cell_state;
    } t_result;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_CLR,
        DP_LOAD,
        DP_MUL,
        DP_MIX2,
        DP_DIVST,
        DP_HEAD_RD,
        DP_CUR_HEAD,
        DP_NODE_RD,
        DP_STEP,
        DP_HEAD_UNLINK,
        DP_PREV_UNLINK,
        DP_FREE,
        DP_WR_UPD,
        DP_ALLOC_FRESH,
        DP_ALLOC_RD,
        DP_ALLOC_POP,
        DP_INS_NODE,
        DP_INS_HEAD,
        DP_RESULT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   set_res;
        t_res   res;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic clr_last;
        logic cur_nil;
        logic prev_nil;
        logic key_match;
        logic is_set;
        logic is_del;
        logic pool_empty;
        logic pool_fresh;
        logic out_free;
    } t_stat;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_MIX2,
        S_DIVST,
        S_DIV,
        S_HRD,
        S_HSET,
        S_NRD,
        S_CMP,
        S_DECIDE,
        S_FREE,
        S_ALLOC,
        S_INS,
        S_INS2,
        S_DONE
    } t_state;

endpackage

[sv/chct_div.sv]
module chct_div
    import chct_pkg::*;
#(
    parameter int BW = 11
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [HASH_W-1:0] i_dividend,
    input  logic [BW-1:0]     i_divisor,
    output logic              o_done,
    output logic [BW-1:0]     o_rem
);

    // Restoring remainder, one dividend bit per cycle.
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [4:0]        r_cnt, n_cnt;
    logic [HASH_W-1:0] r_q, n_q;
    logic [BW-1:0]     r_rem, n_rem;
    logic [BW-1:0]     r_d, n_d;
    logic [BW:0]       w_trial;

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_q     = r_q;
        n_rem   = r_rem;
        n_d     = r_d;
        w_trial = {r_rem, r_q[HASH_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_q    = i_dividend;
            n_rem  = '0;
            n_d    = i_divisor;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_d}) begin
                n_rem = BW'(w_trial - {1'b0, r_d});
            end else begin
                n_rem = BW'(w_trial);
            end
            n_q   = {r_q[HASH_W-2:0], 1'b0};
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'(HASH_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_d   <= n_d;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

[sv/chct_dp.sv]
module chct_dp
    import chct_pkg::*;
#(
    parameter int BUCKETS = 1024,
    parameter int NODES   = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  t_item            i_item,
    input  logic             i_stall,
    output logic             o_valid,
    output t_result          o_result,
    input  t_cmd             i_cmd,
    output t_stat            o_stat
);

    localparam int BW = $clog2(BUCKETS + 1);
    localparam int BI = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int PW = $clog2(NODES + 1);
    localparam int NI = $clog2(NODES);
    localparam logic [PW-1:0] NIL = PW'(NODES);

    typedef struct packed {
        logic [15:0]   x;
        logic [15:0]   y;
        logic [3:0]    st;
        logic [PW-1:0] nxt;
    } t_node;

    logic [PW-1:0] m_heads [BUCKETS];
    t_node         m_nodes [NODES];

    logic [10:0]       r_bcount;
    logic [3:0]        r_empty;
    t_item             r_item;
    logic [HASH_W-1:0] r_mix;
    logic [BI-1:0]     r_bucket;
    logic [BI-1:0]     r_clr;
    logic [PW-1:0]     r_head_q;
    t_node             r_node_q;
    t_node             r_prev_w;
    logic [PW-1:0]     r_cur, r_prev, r_new;
    logic [PW-1:0]     r_free, r_fill;
    t_res              r_res;
    logic [3:0]        r_cs;
    logic              r_out_valid;
    t_result           r_out;

    logic [BW-1:0]     w_div;
    logic [BW-1:0]     w_rem;
    logic              w_div_done;
    logic [HASH_W-1:0] w_comb;
    logic              w_h_we;
    logic [BI-1:0]     w_h_addr;
    logic [PW-1:0]     w_h_data;
    logic              w_n_we;
    logic [PW-1:0]     w_n_addr;
    t_node             w_n_data;
    logic [PW-1:0]     w_n_raddr;

    // Effective divisor: zero acts as one, above BUCKETS acts as BUCKETS.
    always_comb begin
        if (r_bcount == '0) begin
            w_div = BW'(1);
        end else if (32'(r_bcount) > 32'(BUCKETS)) begin
            w_div = BW'(BUCKETS);
        end else begin
            w_div = BW'(r_bcount);
        end
    end

    assign w_comb = {i_item.x_coord, 16'h0000} | {{16{i_item.y_coord[15]}}, i_item.y_coord};

    chct_div #(.BW(BW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.op == DP_DIVST),
        .i_dividend (r_mix),
        .i_divisor  (w_div),
        .o_done     (w_div_done),
        .o_rem      (w_rem)
    );

    // Write port selection for the two memories.
    always_comb begin
        w_h_we    = 1'b0;
        w_h_addr  = r_bucket;
        w_h_data  = NIL;
        w_n_we    = 1'b0;
        w_n_addr  = r_cur;
        w_n_data  = r_node_q;
        w_n_raddr = r_cur;
        unique case (i_cmd.op)
            DP_CLR: begin
                w_h_we   = 1'b1;
                w_h_addr = r_clr;
            end
            DP_HEAD_UNLINK: begin
                w_h_we   = 1'b1;
                w_h_data = r_node_q.nxt;
            end
            DP_INS_HEAD: begin
                w_h_we   = 1'b1;
                w_h_data = r_new;
            end
            DP_PREV_UNLINK: begin
                w_n_we       = 1'b1;
                w_n_addr     = r_prev;
                w_n_data     = r_prev_w;
                w_n_data.nxt = r_node_q.nxt;
            end
            DP_FREE: begin
                w_n_we       = 1'b1;
                w_n_data.nxt = r_free;
            end
            DP_WR_UPD: begin
                w_n_we      = 1'b1;
                w_n_data.st = r_item.new_state;
            end
            DP_INS_NODE: begin
                w_n_we   = 1'b1;
                w_n_addr = r_new;
                w_n_data = '{x: r_item.x_coord, y: r_item.y_coord,
                             st: r_item.new_state, nxt: r_head_q};
            end
            DP_ALLOC_RD: begin
                w_n_raddr = r_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_h_we) begin
            m_heads[w_h_addr] <= w_h_data;
        end
        if (i_cmd.op == DP_HEAD_RD) begin
            r_head_q <= m_heads[BI'(w_rem)];
        end
        if (w_n_we) begin
            m_nodes[w_n_addr[NI-1:0]] <= w_n_data;
        end
        if (i_cmd.op == DP_NODE_RD || i_cmd.op == DP_ALLOC_RD) begin
            r_node_q <= m_nodes[w_n_raddr[NI-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcount    <= BUCKET_COUNT_RST;
            r_empty     <= EMPTY_CODE_RST;
            r_clr       <= '0;
            r_free      <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_BUCKET_COUNT: r_bcount <= i_cfg_data;
                    CFG_EMPTY_CODE:   r_empty  <= i_cfg_data[3:0];
                endcase
            end
            if (i_cmd.op == DP_CLR) begin
                r_clr <= r_clr + BI'(1);
            end
            if (i_cmd.op == DP_FREE) begin
                r_free <= r_cur;
            end
            if (i_cmd.op == DP_ALLOC_FRESH) begin
                r_free <= r_fill + PW'(1);
                r_fill <= r_fill + PW'(1);
            end
            if (i_cmd.op == DP_ALLOC_POP) begin
                r_free <= r_node_q.nxt;
            end
            if (i_cmd.op == DP_RESULT) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        unique case (i_cmd.op)
            DP_LOAD: begin
                r_item <= i_item;
                r_mix  <= w_comb ^ (w_comb >> HASH_SHIFT_A);
            end
            DP_MUL:      r_mix    <= r_mix * HASH_MULT;
            DP_MIX2:     r_mix    <= r_mix ^ (r_mix >> HASH_SHIFT_B);
            DP_HEAD_RD:  r_bucket <= BI'(w_rem);
            DP_CUR_HEAD: begin
                r_cur  <= r_head_q;
                r_prev <= NIL;
            end
            DP_STEP: begin
                r_prev   <= r_cur;
                r_prev_w <= r_node_q;
                r_cur    <= r_node_q.nxt;
            end
            DP_ALLOC_FRESH: r_new <= r_free;
            DP_ALLOC_POP:   r_new <= r_free;
            DP_RESULT: begin
                r_out.ok         <= (r_res != RES_MISS);
                r_out.status     <= r_res;
                r_out.cell_state <= r_cs;
            end
            default: begin
            end
        endcase
        if (i_cmd.set_res) begin
            r_res <= i_cmd.res;
            r_cs  <= (i_cmd.res == RES_HIT) ? r_node_q.st : 4'd0;
        end
    end

    always_comb begin
        o_stat.div_done   = w_div_done;
        o_stat.clr_last   = (r_clr == BI'(BUCKETS - 1));
        o_stat.cur_nil    = (r_cur == NIL);
        o_stat.prev_nil   = (r_prev == NIL);
        o_stat.key_match  = (r_node_q.x == r_item.x_coord) && (r_node_q.y == r_item.y_coord);
        o_stat.is_set     = r_item.func;
        o_stat.is_del     = (r_item.new_state == r_empty);
        o_stat.pool_empty = (r_free == NIL);
        o_stat.pool_fresh = (r_free == r_fill);
        o_stat.out_free   = !r_out_valid || !i_stall;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // Recycled nodes always lie below the fill mark.
    a_free_below_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= r_fill || r_free == NIL)
        else $error("free head beyond fill mark");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= NIL)
        else $error("fill mark beyond pool");

    a_result_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == DP_RESULT |-> (!r_out_valid || !i_stall))
        else $error("result loaded over a waiting item");

    a_alloc_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == DP_ALLOC_FRESH || i_cmd.op == DP_ALLOC_RD) |-> r_free != NIL)
        else $error("allocation from empty pool");

endmodule

[sv/chct_ctl.sv]
module chct_ctl
    import chct_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd.op      = DP_NOP;
        o_cmd.set_res = 1'b0;
        o_cmd.res     = RES_MISS;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.op = DP_CLR;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = DP_LOAD;
                    n_state  = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.op = DP_MUL;
                n_state  = S_MIX2;
            end
            S_MIX2: begin
                o_cmd.op = DP_MIX2;
                n_state  = S_DIVST;
            end
            S_DIVST: begin
                o_cmd.op = DP_DIVST;
                n_state  = S_DIV;
            end
            S_DIV: begin
                if (i_stat.div_done) n_state = S_HRD;
            end
            S_HRD: begin
                o_cmd.op = DP_HEAD_RD;
                n_state  = S_HSET;
            end
            S_HSET: begin
                o_cmd.op = DP_CUR_HEAD;
                n_state  = S_NRD;
            end
            S_NRD: begin
                if (i_stat.cur_nil) begin
                    n_state = S_DECIDE;
                end else begin
                    o_cmd.op = DP_NODE_RD;
                    n_state  = S_CMP;
                end
            end
            S_CMP: begin
                if (i_stat.key_match) begin
                    n_state = S_DECIDE;
                end else begin
                    o_cmd.op = DP_STEP;
                    n_state  = S_NRD;
                end
            end
            S_DECIDE: begin
                priority if (!i_stat.is_set) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res     = i_stat.cur_nil ? RES_MISS : RES_HIT;
                    n_state       = S_DONE;
                end else if (i_stat.is_del) begin
                    if (i_stat.cur_nil) begin
                        o_cmd.set_res = 1'b1;
                        n_state       = S_DONE;
                    end else begin
                        o_cmd.op = i_stat.prev_nil ? DP_HEAD_UNLINK : DP_PREV_UNLINK;
                        n_state  = S_FREE;
                    end
                end else if (!i_stat.cur_nil) begin
                    o_cmd.op      = DP_WR_UPD;
                    o_cmd.set_res = 1'b1;
                    o_cmd.res     = RES_UPD;
                    n_state       = S_DONE;
                end else if (i_stat.pool_empty) begin
                    o_cmd.set_res = 1'b1;
                    n_state       = S_DONE;
                end else if (i_stat.pool_fresh) begin
                    o_cmd.op = DP_ALLOC_FRESH;
                    n_state  = S_INS;
                end else begin
                    o_cmd.op = DP_ALLOC_RD;
                    n_state  = S_ALLOC;
                end
            end
            S_FREE: begin
                o_cmd.op      = DP_FREE;
                o_cmd.set_res = 1'b1;
                o_cmd.res     = RES_REM;
                n_state       = S_DONE;
            end
            S_ALLOC: begin
                o_cmd.op = DP_ALLOC_POP;
                n_state  = S_INS;
            end
            S_INS: begin
                o_cmd.op = DP_INS_NODE;
                n_state  = S_INS2;
            end
            S_INS2: begin
                o_cmd.op      = DP_INS_HEAD;
                o_cmd.set_res = 1'b1;
                o_cmd.res     = RES_INS;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.op = DP_RESULT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_stall = (r_state != S_IDLE);

    a_done_from_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_HRD |-> $past(r_state) == S_DIV)
        else $error("head read without finished hash");

    a_clear_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |-> o_stall)
        else $error("item taken during clearing pass");

    a_walk_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CMP |-> $past(o_cmd.op) == DP_NODE_RD)
        else $error("compare without node read");

endmodule

[sv/chained_hash_cell_table.sv]
// Hash table of cell states keyed by signed (x, y) coordinates, with chained buckets
// in a fixed node pool. Each input item is a get or a set; a set whose state equals
// the empty code deletes the key. Every item yields exactly one result item with
// ok, status (hit, updated, inserted, removed or miss, also for a full pool) and the stored state
// on a get hit. Items are handled one at a time. The bucket modulo unit (one dividend
// bit per cycle) dominates the time an item takes, and the chain walk costs one
// registered node-memory read and one compare per node. A finished result sits in
// an output register so the next item can be taken while it waits. After reset the
// bucket head memory is cleared in a pass over all BUCKETS entries, during which no
// item is accepted; configuration writes are taken at any time but are meant for
// idle periods. Free pool nodes are tracked with a fill mark plus a recycled list,
// so the node memory needs no clearing.
module chained_hash_cell_table
    import chct_pkg::*;
#(
    parameter int BUCKETS = 1024,
    parameter int NODES   = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_valid,
    output logic             o_stall,
    input  t_item            i_item,
    output logic             o_valid,
    input  logic             i_stall,
    output t_result          o_result
);

    // Command and status between the sequencer and the datapath.
    t_cmd  w_cmd;
    t_stat w_stat;

    chct_ctl u_ctl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    chct_dp #(
        .BUCKETS (BUCKETS),
        .NODES   (NODES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_item),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat)
    );

endmodule

[dv/tb_chained_hash_cell_table.sv]
module tb_chained_hash_cell_table;
    import chct_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BUCKETS = 1024;
    localparam int NODES   = 4096;
    localparam int NIL     = NODES;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic             i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;
    logic             i_valid;
    logic             o_stall;
    t_item            i_item;
    logic             o_valid;
    logic             i_stall;
    t_result          o_result;

    chained_hash_cell_table #(
        .BUCKETS(BUCKETS),
        .NODES  (NODES)
    ) uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_item    (i_item),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_result  (o_result)
    );

    // Shadow copy of the table. Node keys are stored as raw 16-bit coordinates.
    int          tbl_head[BUCKETS];
    logic [15:0] tbl_x[NODES];
    logic [15:0] tbl_y[NODES];
    logic [3:0]  tbl_state[NODES];
    int          tbl_next[NODES];
    int          tbl_free;
    int unsigned tbl_nbuckets;
    logic [3:0]  tbl_empty;

    // Items waiting to be offered, and the results owed by the block, oldest first.
    t_item   pending_items[$];
    t_result owed_results[$];

    int  fail_count;
    int  checked_count;
    int  accepted_count;
    int  hold_cycles;     // long receiver hold-off, counted by the monitor
    bit  hold_request;
    int  send_gap;
    int  recv_gap;
    int  n_ins, n_rem, n_full, n_hit;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The bucket hash: the y part is sign-extended before it is merged with x.
    function automatic int unsigned hash_bucket(logic [15:0] x, logic [15:0] y);
        logic [31:0] mix;
        int unsigned n;
        mix = {x, 16'h0} | {{16{y[15]}}, y};
        mix = mix ^ (mix >> HASH_SHIFT_A);
        mix = mix * HASH_MULT;
        mix = mix ^ (mix >> HASH_SHIFT_B);
        n = tbl_nbuckets;
        if (n == 0) n = 1;
        if (n > BUCKETS) n = BUCKETS;
        return mix % n;
    endfunction

    function automatic void table_clear();
        for (int i = 0; i < BUCKETS; i++) tbl_head[i] = NIL;
        for (int i = 0; i < NODES; i++) begin
            tbl_x[i] = '0;
            tbl_y[i] = '0;
            tbl_state[i] = '0;
            tbl_next[i] = i + 1;
        end
        tbl_free = 0;
        tbl_nbuckets = 32'(BUCKET_COUNT_RST);
        tbl_empty = EMPTY_CODE_RST;
    endfunction

    // Applies one item to the shadow table and returns the answer the block owes.
    function automatic t_result table_apply(t_item it);
        t_result     r;
        int unsigned b;
        int          prev;
        int          cur;
        int          steps;
        int          n;
        r.ok = 1'b0;
        r.status = RES_MISS;
        r.cell_state = '0;
        b = hash_bucket(it.x_coord, it.y_coord);
        prev = NIL;
        cur = tbl_head[b];
        steps = 0;
        while (cur < NODES && steps < NODES) begin
            if (tbl_x[cur] == it.x_coord && tbl_y[cur] == it.y_coord) break;
            prev = cur;
            cur = tbl_next[cur];
            steps++;
        end
        if (cur >= NODES || steps >= NODES) cur = NIL;
        if (it.func == 1'b0) begin
            if (cur != NIL) begin
                r.ok = 1'b1;
                r.status = RES_HIT;
                r.cell_state = tbl_state[cur];
                n_hit++;
            end
        end else if (it.new_state == tbl_empty) begin
            if (cur != NIL) begin
                if (prev == NIL) tbl_head[b] = tbl_next[cur];
                else tbl_next[prev] = tbl_next[cur];
                tbl_next[cur] = tbl_free;
                tbl_free = cur;
                r.ok = 1'b1;
                r.status = RES_REM;
                n_rem++;
            end
        end else if (cur != NIL) begin
            tbl_state[cur] = it.new_state;
            r.ok = 1'b1;
            r.status = RES_UPD;
        end else if (tbl_free < NODES) begin
            n = tbl_free;
            tbl_free = tbl_next[n];
            tbl_x[n] = it.x_coord;
            tbl_y[n] = it.y_coord;
            tbl_state[n] = it.new_state;
            tbl_next[n] = tbl_head[b];
            tbl_head[b] = n;
            r.ok = 1'b1;
            r.status = RES_INS;
            n_ins++;
        end else begin
            n_full++;
        end
        return r;
    endfunction

    // Driver: offers the queued items one by one, with a drawn gap before each.
    // The payload and valid stay put while the block stalls.
    always @(posedge i_clk) begin
        int gap;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap <= 0;
        end else if (i_valid && !o_stall) begin
            accepted_count <= accepted_count + 1;
            owed_results.push_back(table_apply(i_item));
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
            send_gap <= gap;
            if (gap == 0 && pending_items.size() > 0) begin
                i_item <= pending_items.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end else if (!i_valid) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
            end else if (pending_items.size() > 0) begin
                i_item <= pending_items.pop_front();
                i_valid <= 1'b1;
            end
        end
    end

    // Monitor: checks each accepted result against the oldest owed one, and
    // drives the stall with drawn gaps or a long hold-off when asked.
    always @(posedge i_clk) begin
        t_result want;
        int      gap;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            recv_gap <= 0;
            hold_cycles <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (owed_results.size() == 0) begin
                    $error("result item with nothing expected: %p", o_result);
                    fail_count++;
                end else begin
                    want = owed_results.pop_front();
                    checked_count++;
                    if (o_result.ok !== want.ok) begin
                        $error("ok: expected %0d, got %0d", want.ok, o_result.ok);
                        fail_count++;
                    end
                    if (o_result.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status,
                               o_result.status);
                        fail_count++;
                    end
                    if (o_result.cell_state !== want.cell_state) begin
                        $error("cell_state: expected %0d, got %0d", want.cell_state,
                               o_result.cell_state);
                        fail_count++;
                    end
                end
            end
            if (hold_request && hold_cycles == 0) begin
                hold_cycles <= 600;
                hold_request = 1'b0;
                i_stall <= 1'b1;
            end else if (hold_cycles > 1) begin
                hold_cycles <= hold_cycles - 1;
            end else if (hold_cycles == 1) begin
                hold_cycles <= 0;
                i_stall <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                if (recv_gap == 1) i_stall <= 1'b0;
            end else if (o_valid && !i_stall) begin
                // A new wait is drawn for every item taken; about a third go unstalled.
                gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 8);
                recv_gap <= gap;
                if (gap > 0) i_stall <= 1'b1;
            end else if (recv_gap == 0 && $urandom_range(0, 15) == 0) begin
                recv_gap <= $urandom_range(1, 8);
                i_stall <= 1'b1;
            end
        end
    end

    function automatic t_item make_item(logic func, logic [15:0] x, logic [15:0] y,
                                        logic [3:0] st);
        t_item it;
        it.func = func;
        it.x_coord = x;
        it.y_coord = y;
        it.new_state = st;
        return it;
    endfunction

    // Waits until everything queued has gone in and every result has come back,
    // then lets the block finish any trailing work. The check runs at the falling
    // edge so that the driver's updates of the same rising edge are already seen.
    task automatic drain();
        while (pending_items.size() > 0 || i_valid || owed_results.size() > 0)
            @(negedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        if (idx == CFG_BUCKET_COUNT) tbl_nbuckets = 32'(value);
        else tbl_empty = value[3:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Random coordinates come mostly from a small window so that sets hit earlier
    // keys and chains grow; the rest roam the full signed range or sit at its two ends.
    function automatic logic [15:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return 16'($urandom());
            1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            default: return 16'($signed($urandom_range(0, 15)) - 8);
        endcase
    endfunction

    // A phase of random traffic: a mix of gets, stores and deletes.
    task automatic random_phase(int count);
        logic [3:0] st;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: st = 4'($urandom());
                4, 5:       st = tbl_empty;
                default:    st = 4'($urandom());
            endcase
            pending_items.push_back(make_item(1'($urandom_range(0, 1)), pick_coord(),
                                              pick_coord(), st));
        end
    endtask

    initial begin
        fail_count = 0;
        checked_count = 0;
        accepted_count = 0;
        hold_request = 1'b0;
        n_ins = 0;
        n_rem = 0;
        n_full = 0;
        n_hit = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_BUCKET_COUNT;
        i_cfg_data = '0;
        table_clear();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: field extremes, every operation, update, delete of an
        // absent key, and a get of a key whose state is the new empty code.
        pending_items.push_back(make_item(1'b0, 16'h8000, 16'h8000, 4'hf));
        pending_items.push_back(make_item(1'b1, 16'h8000, 16'h8000, 4'hf));
        pending_items.push_back(make_item(1'b1, 16'h7fff, 16'h7fff, 4'h0));
        pending_items.push_back(make_item(1'b1, 16'h0000, 16'hffff, 4'h5));
        pending_items.push_back(make_item(1'b1, 16'hffff, 16'h0000, 4'h3));
        pending_items.push_back(make_item(1'b0, 16'h8000, 16'h8000, 4'h0));
        pending_items.push_back(make_item(1'b0, 16'h7fff, 16'h7fff, 4'h0));
        pending_items.push_back(make_item(1'b1, 16'h7fff, 16'h7fff, 4'h9));
        pending_items.push_back(make_item(1'b0, 16'h7fff, 16'h7fff, 4'h0));
        pending_items.push_back(make_item(1'b1, 16'h1234, 16'h5678, EMPTY_CODE_RST));
        pending_items.push_back(make_item(1'b1, 16'h0000, 16'hffff, EMPTY_CODE_RST));
        pending_items.push_back(make_item(1'b0, 16'h0000, 16'hffff, 4'h0));
        pending_items.push_back(make_item(1'b0, 16'hffff, 16'h0000, 4'h0));
        drain();
        write_reg(CFG_EMPTY_CODE, 11'd3);
        pending_items.push_back(make_item(1'b0, 16'hffff, 16'h0000, 4'h0));
        pending_items.push_back(make_item(1'b1, 16'hffff, 16'h0000, 4'h3));
        pending_items.push_back(make_item(1'b0, 16'hffff, 16'h0000, 4'h0));
        drain();

        // One bucket: every key shares a chain, and the old entries stay stranded
        // in their earlier buckets. Then zero, which acts as one.
        write_reg(CFG_BUCKET_COUNT, 11'd1);
        random_phase(200);
        drain();
        write_reg(CFG_BUCKET_COUNT, 11'd0);
        write_reg(CFG_EMPTY_CODE, 11'd0);
        random_phase(150);

        // The sender keeps offering while the receiver holds off, so the block
        // fills up and stalls its input.
        hold_request = 1'b1;
        drain();

        // Above the bucket array size, then a small odd count, then the largest.
        write_reg(CFG_BUCKET_COUNT, 11'h7ff);
        write_reg(CFG_EMPTY_CODE, 11'd15);
        random_phase(300);
        drain();
        write_reg(CFG_BUCKET_COUNT, 11'd7);
        write_reg(CFG_EMPTY_CODE, 11'd7);
        random_phase(400);
        drain();
        write_reg(CFG_BUCKET_COUNT, 11'd1024);
        write_reg(CFG_EMPTY_CODE, 11'd2);
        random_phase(780);
        drain();

        $display("Covered %0d items: %0d hits, %0d inserts, %0d removals, %0d pool full,",
                 accepted_count, n_hit, n_ins, n_rem, n_full);
        $display("over bucket counts 0, 1, 7, 1024 and 2047 and five empty codes.");
        if (fail_count == 0 && owed_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Worst case is roughly 1850 items, each walking a chain of up to a couple of
    // thousand nodes, with the longest stalls on both sides.
    initial begin
        #200ms;
        $display("Some tests failed");
        $finish;
    end

endmodule

[files.f]
sv/chct_pkg.sv
sv/chct_div.sv
sv/chct_dp.sv
sv/chct_ctl.sv
sv/chained_hash_cell_table.sv
dv/tb_chained_hash_cell_table.sv
